FILE: rtl/dasd_pkg.sv
// Shared types, constants and calendar tables for the date add/subtract block.
package dasd_pkg;

  // Parameter defaults
  localparam int DASD_OFFSET_BITS = 16;
  localparam int DASD_YEAR_MAX    = 9999;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DATE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  // Cycle lengths in days
  localparam int Days400Y = 146097;
  localparam int Days100Y = 36524;
  localparam int Days4Y   = 1461;
  localparam int Days1Y   = 365;

  // Echo of the input date plus error flags, carried down the pipe
  typedef struct packed {
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic        bad;
    logic        oor;
  } dasd_tag_t;

  // Length of a month; zero for a code that is no month
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days of a common year before the first of month m
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] c;
    unique case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/dasd_serial.sv
// Front pipeline: date check, date to day serial, offset add or subtract.
module dasd_serial import dasd_pkg::*; #(
  parameter int OFFSET_BITS = DASD_OFFSET_BITS,
  parameter int YEAR_MAX    = DASD_YEAR_MAX,
  localparam int OW = (OFFSET_BITS < 16) ? OFFSET_BITS : 16,
  localparam int NW = ((OW > 23) ? OW : 23) + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_v,
  input  logic          in_act,
  input  logic [13:0]   in_y,
  input  logic [3:0]    in_m,
  input  logic [4:0]    in_d,
  input  logic [15:0]   in_off,
  output logic          o_v,
  output logic [NW-1:0] o_n,
  output dasd_tag_t     o_tag
);

  // Stage 1: year / 100 by reciprocal (5243 / 2^19, exact below 2^14)
  logic          s1_v_r, s1_act_r;
  logic [OW-1:0] s1_off_r;
  dasd_tag_t     s1_tag_r;
  logic [7:0]    s1_q100_r;
  logic [26:0]   s1_prod;
  dasd_tag_t     s1_tag_nxt;

  assign s1_prod = 27'(in_y) * 27'(5243);

  always_comb begin
    s1_tag_nxt     = '0;
    s1_tag_nxt.y   = in_y;
    s1_tag_nxt.m   = in_m;
    s1_tag_nxt.d   = in_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_act_r  <= in_act;
      s1_off_r  <= in_off[OW-1:0];
      s1_tag_r  <= s1_tag_nxt;
      s1_q100_r <= s1_prod[26:19];
    end
  end

  // Stage 2: leap rule, validity, day of year, century terms
  logic          s2_v_r, s2_act_r;
  logic [OW-1:0] s2_off_r;
  dasd_tag_t     s2_tag_r;
  logic [13:0]   s2_p_r;
  logic [7:0]    s2_pq100_r;
  logic [8:0]    s2_yday_r;
  logic [13:0]   r100;
  logic          leap;
  logic [7:0]    pq100_nxt;
  logic [4:0]    dim;
  logic          bad_nxt;
  logic [8:0]    yday_nxt;
  dasd_tag_t     s2_tag_nxt;

  always_comb begin
    r100       = s1_tag_r.y - 14'(s1_q100_r) * 14'd100;
    leap       = ((s1_tag_r.y[1:0] == 2'd0) && (r100 != 14'd0)) ||
                 ((r100 == 14'd0) && (s1_q100_r[1:0] == 2'd0));
    pq100_nxt  = (r100 == 14'd0) ? s1_q100_r - 8'd1 : s1_q100_r;
    dim        = month_len(s1_tag_r.m, leap);
    bad_nxt    = (s1_tag_r.y == 14'd0) || (32'(s1_tag_r.y) > YEAR_MAX) ||
                 (s1_tag_r.d == 5'd0) || (s1_tag_r.d > dim) || (dim == 5'd0);
    yday_nxt   = cum_days(s1_tag_r.m) + 9'(leap && (s1_tag_r.m > 4'd2)) +
                 9'(s1_tag_r.d) - 9'd1;
    s2_tag_nxt     = s1_tag_r;
    s2_tag_nxt.bad = bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_act_r   <= s1_act_r;
      s2_off_r   <= s1_off_r;
      s2_tag_r   <= s2_tag_nxt;
      s2_p_r     <= s1_tag_r.y - 14'd1;
      s2_pq100_r <= pq100_nxt;
      s2_yday_r  <= yday_nxt;
    end
  end

  // Stage 3: serial day number from 0001-01-01
  logic          s3_v_r, s3_act_r;
  logic [OW-1:0] s3_off_r;
  dasd_tag_t     s3_tag_r;
  logic [NW-1:0] s3_ser_r;
  logic [NW-1:0] ser_nxt;

  assign ser_nxt = NW'(s2_p_r) * NW'(Days1Y) + NW'(s2_p_r >> 2) - NW'(s2_pq100_r) +
                   NW'(s2_pq100_r >> 2) + NW'(s2_yday_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_act_r <= s2_act_r;
      s3_off_r <= s2_off_r;
      s3_tag_r <= s2_tag_r;
      s3_ser_r <= ser_nxt;
    end
  end

  // Stage 4: apply the offset, flag a result before day zero
  logic          s4_v_r;
  dasd_tag_t     s4_tag_r;
  logic [NW-1:0] s4_n_r;
  logic [NW-1:0] n_nxt;
  dasd_tag_t     s4_tag_nxt;

  always_comb begin
    s4_tag_nxt = s3_tag_r;
    if (!s3_act_r) begin
      n_nxt = s3_ser_r + NW'(s3_off_r);
    end else begin
      n_nxt          = s3_ser_r - NW'(s3_off_r);
      s4_tag_nxt.oor = (NW'(s3_off_r) > s3_ser_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_tag_r <= s4_tag_nxt;
      s4_n_r   <= n_nxt;
    end
  end

  assign o_v   = s4_v_r;
  assign o_n   = s4_n_r;
  assign o_tag = s4_tag_r;

endmodule

FILE: rtl/dasd_civil.sv
// Back pipeline: day serial to year, month and day of year.
module dasd_civil import dasd_pkg::*; #(
  parameter int NW = 24,
  localparam int QW = NW - 16,
  localparam int KW = NW - 15,
  localparam int S4 = NW + 1,
  localparam int K400 = (2 ** S4) / Days400Y,
  localparam int YW = NW - 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_v,
  input  logic [NW-1:0] in_n,
  input  dasd_tag_t     in_tag,
  output logic          o_v,
  output dasd_tag_t     o_tag,
  output logic [YW-1:0] o_year,
  output logic [3:0]    o_mo,
  output logic [8:0]    o_r,
  output logic          o_leap
);

  // B1: estimate of n / 146097, low by at most one
  logic             b1_v_r;
  dasd_tag_t        b1_tag_r;
  logic [NW-1:0]    b1_n_r;
  logic [QW-1:0]    b1_q_r;
  logic [NW+KW-1:0] b1_prod;

  assign b1_prod = (NW+KW)'(in_n) * (NW+KW)'(K400);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
    end else if (adv) begin
      b1_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_tag_r <= in_tag;
      b1_n_r   <= in_n;
      b1_q_r   <= b1_prod[NW+KW-1:S4];
    end
  end

  // B2: remainder and one correction step
  logic          b2_v_r;
  dasd_tag_t     b2_tag_r;
  logic [QW-1:0] b2_q400_r;
  logic [17:0]   b2_r_r;
  logic [NW-1:0] rem400;
  logic          fix400;

  always_comb begin
    rem400 = b1_n_r - NW'(b1_q_r) * NW'(Days400Y);
    fix400 = (rem400 >= NW'(Days400Y));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_v_r <= 1'b0;
    end else if (adv) begin
      b2_v_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_tag_r  <= b1_tag_r;
      b2_q400_r <= fix400 ? b1_q_r + QW'(1) : b1_q_r;
      b2_r_r    <= fix400 ? 18'(rem400 - NW'(Days400Y)) : 18'(rem400);
    end
  end

  // B3: century within the 400-year cycle, last one holds the extra day
  logic          b3_v_r;
  dasd_tag_t     b3_tag_r;
  logic [QW-1:0] b3_q400_r;
  logic [1:0]    b3_q100_r;
  logic [15:0]   b3_r_r;
  logic [1:0]    q100_nxt;

  always_comb begin
    priority if (b2_r_r >= 18'(3 * Days100Y)) q100_nxt = 2'd3;
    else if (b2_r_r >= 18'(2 * Days100Y))     q100_nxt = 2'd2;
    else if (b2_r_r >= 18'(Days100Y))         q100_nxt = 2'd1;
    else                                      q100_nxt = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b3_v_r <= 1'b0;
    end else if (adv) begin
      b3_v_r <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b3_tag_r  <= b2_tag_r;
      b3_q400_r <= b2_q400_r;
      b3_q100_r <= q100_nxt;
      b3_r_r    <= 16'(b2_r_r - 18'(q100_nxt) * 18'(Days100Y));
    end
  end

  // B4: estimate of r / 1461 (89 / 2^17)
  logic          b4_v_r;
  dasd_tag_t     b4_tag_r;
  logic [QW-1:0] b4_q400_r;
  logic [1:0]    b4_q100_r;
  logic [15:0]   b4_r_r;
  logic [5:0]    b4_q_r;
  logic [22:0]   b4_prod;

  assign b4_prod = 23'(b3_r_r) * 23'((2 ** 17) / Days4Y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b4_v_r <= 1'b0;
    end else if (adv) begin
      b4_v_r <= b3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b4_tag_r  <= b3_tag_r;
      b4_q400_r <= b3_q400_r;
      b4_q100_r <= b3_q100_r;
      b4_r_r    <= b3_r_r;
      b4_q_r    <= b4_prod[22:17];
    end
  end

  // B5: remainder of the four-year cycle with one correction
  logic          b5_v_r;
  dasd_tag_t     b5_tag_r;
  logic [QW-1:0] b5_q400_r;
  logic [1:0]    b5_q100_r;
  logic [5:0]    b5_q4_r;
  logic [10:0]   b5_r_r;
  logic [15:0]   rem4;
  logic          fix4;

  always_comb begin
    rem4 = b4_r_r - 16'(b4_q_r) * 16'(Days4Y);
    fix4 = (rem4 >= 16'(Days4Y));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b5_v_r <= 1'b0;
    end else if (adv) begin
      b5_v_r <= b4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b5_tag_r  <= b4_tag_r;
      b5_q400_r <= b4_q400_r;
      b5_q100_r <= b4_q100_r;
      b5_q4_r   <= fix4 ? b4_q_r + 6'd1 : b4_q_r;
      b5_r_r    <= fix4 ? 11'(rem4 - 16'(Days4Y)) : 11'(rem4);
    end
  end

  // B6: year within the four-year cycle, year number, leap flag
  logic          b6_v_r;
  dasd_tag_t     b6_tag_r;
  logic [YW-1:0] b6_year_r;
  logic [8:0]    b6_r_r;
  logic          b6_leap_r;
  logic [1:0]    q1;

  always_comb begin
    priority if (b5_r_r >= 11'(3 * Days1Y)) q1 = 2'd3;
    else if (b5_r_r >= 11'(2 * Days1Y))     q1 = 2'd2;
    else if (b5_r_r >= 11'(Days1Y))         q1 = 2'd1;
    else                                    q1 = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b6_v_r <= 1'b0;
    end else if (adv) begin
      b6_v_r <= b5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b6_tag_r  <= b5_tag_r;
      b6_r_r    <= 9'(b5_r_r - 11'(q1) * 11'(Days1Y));
      // leap when last year of a four-year block, unless a plain century end
      b6_leap_r <= (q1 == 2'd3) && ((b5_q4_r != 6'd24) || (b5_q100_r == 2'd3));
      b6_year_r <= YW'(1) + YW'(b5_q400_r) * YW'(400) + YW'(b5_q100_r) * YW'(100) +
                   YW'(b5_q4_r) * YW'(4) + YW'(q1);
    end
  end

  // B7: month by parallel compares against month starts
  logic          b7_v_r;
  dasd_tag_t     b7_tag_r;
  logic [YW-1:0] b7_year_r;
  logic [3:0]    b7_mo_r;
  logic [8:0]    b7_r_r;
  logic          b7_leap_r;
  logic [3:0]    mo_nxt;

  always_comb begin
    mo_nxt = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (b6_r_r >= cum_days(4'(k)) + 9'(b6_leap_r && (k > 2))) begin
        mo_nxt = mo_nxt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b7_v_r <= 1'b0;
    end else if (adv) begin
      b7_v_r <= b6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b7_tag_r  <= b6_tag_r;
      b7_year_r <= b6_year_r;
      b7_mo_r   <= mo_nxt;
      b7_r_r    <= b6_r_r;
      b7_leap_r <= b6_leap_r;
    end
  end

  assign o_v    = b7_v_r;
  assign o_tag  = b7_tag_r;
  assign o_year = b7_year_r;
  assign o_mo   = b7_mo_r;
  assign o_r    = b7_r_r;
  assign o_leap = b7_leap_r;

endmodule

FILE: rtl/date_add_subtract_days.sv
// Top level: Gregorian date plus or minus a day count, fully pipelined.
//
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------------------
//  in_     | in  | tdata: start date and offset, tuser: action (1 subtracts)
//  out_    | out | tdata: result date, tuser: status
//
// An accepted input beat passes four front stages, seven conversion stages
// and the output register on its way to the result beat; a new beat can
// enter every cycle the pipe advances. The whole pipe advances together:
// in_tready follows out_tready whenever a result is held. Reset (rst_n low,
// synchronous) clears every valid bit; data registers keep their contents.
module date_add_subtract_days import dasd_pkg::*; #(
  parameter int OFFSET_BITS = DASD_OFFSET_BITS,
  parameter int YEAR_MAX    = DASD_YEAR_MAX
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [13:0] start_year, [17:14] start_month, [22:18] start_day,
  // [38:23] offset_days, [39] zero
  input  logic [39:0] in_tdata,
  // [0] action
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [13:0] result_year, [17:14] result_month, [22:18] result_day, [23] zero
  output logic [23:0] out_tdata,
  // [1:0] status
  output logic [1:0]  out_tuser
);

  localparam int OW = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;
  localparam int NW = ((OW > 23) ? OW : 23) + 1;
  localparam int YW = NW - 8;

  logic          adv;
  logic          ser_v;
  logic [NW-1:0] ser_n;
  dasd_tag_t     ser_tag;
  logic          civ_v;
  dasd_tag_t     civ_tag;
  logic [YW-1:0] civ_year;
  logic [3:0]    civ_mo;
  logic [8:0]    civ_r;
  logic          civ_leap;

  logic          out_v_r;
  logic [23:0]   out_data_r;
  logic [1:0]    out_st_r;

  // pipe moves when the output slot is empty or being taken
  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv;

  dasd_serial #(
    .OFFSET_BITS (OFFSET_BITS),
    .YEAR_MAX    (YEAR_MAX)
  ) u_serial (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_v   (in_tvalid),
    .in_act (in_tuser[0]),
    .in_y   (in_tdata[13:0]),
    .in_m   (in_tdata[17:14]),
    .in_d   (in_tdata[22:18]),
    .in_off (in_tdata[38:23]),
    .o_v    (ser_v),
    .o_n    (ser_n),
    .o_tag  (ser_tag)
  );

  dasd_civil #(
    .NW (NW)
  ) u_civil (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_v   (ser_v),
    .in_n   (ser_n),
    .in_tag (ser_tag),
    .o_v    (civ_v),
    .o_tag  (civ_tag),
    .o_year (civ_year),
    .o_mo   (civ_mo),
    .o_r    (civ_r),
    .o_leap (civ_leap)
  );

  // Final stage: day of month, range check, status and echo select
  logic [8:0]  start_nxt;
  logic [4:0]  day_nxt;
  logic [23:0] data_nxt;
  logic [1:0]  st_nxt;

  always_comb begin
    start_nxt = cum_days(civ_mo) + 9'(civ_leap && (civ_mo > 4'd2));
    day_nxt   = 5'(civ_r - start_nxt + 9'd1);
    priority if (civ_tag.bad) begin
      st_nxt   = ST_BAD_DATE;
      data_nxt = {1'b0, civ_tag.d, civ_tag.m, civ_tag.y};
    end else if (civ_tag.oor || (32'(civ_year) > YEAR_MAX)) begin
      st_nxt   = ST_RANGE;
      data_nxt = {1'b0, civ_tag.d, civ_tag.m, civ_tag.y};
    end else begin
      st_nxt   = ST_OK;
      data_nxt = {1'b0, day_nxt, civ_mo, civ_year[13:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= civ_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= data_nxt;
      out_st_r   <= st_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_st_r;

  // a good result has a nonzero year, a month from 1 to 12 and a nonzero day
  a_ok_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_OK)) |->
      ((out_tdata[17:14] != 4'd0) && (out_tdata[17:14] <= 4'd12) &&
       (out_tdata[22:18] != 5'd0) && (out_tdata[13:0] != 14'd0)))
    else $error("ok result with impossible date");

  // status code three is never produced
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != 2'd3))
    else $error("undefined status code");

  // reset empties the output slot
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule
